@@ rtl/fus_pkg.sv @@
// Package for the flash update sequencer: action and command codes, job mode
// and phase codes, item and result structs, and the size helper functions.
// No dependencies; every rtl file refers to it by scoped names.
package fus_pkg;

    // Input actions, carried on the slave-side tuser.
    localparam logic [2:0] ACT_START_ERASE = 3'd0;
    localparam logic [2:0] ACT_START_WRITE = 3'd1;
    localparam logic [2:0] ACT_START_COPY  = 3'd2;
    localparam logic [2:0] ACT_FLASH_DONE  = 3'd3;
    localparam logic [2:0] ACT_COMPARE     = 3'd4;

    // Result commands, carried on the master-side tuser.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_ERASE    = 3'd1;
    localparam logic [2:0] CMD_PROGRAM  = 3'd2;
    localparam logic [2:0] CMD_COMPARE  = 3'd3;
    localparam logic [2:0] CMD_JOB_DONE = 3'd4;

    // Job modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ERASE = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_COPY  = 2'd3;

    // Step phases.
    localparam logic [1:0] PH_NONE       = 2'd0;
    localparam logic [1:0] PH_WAIT_ERASE = 2'd1;
    localparam logic [1:0] PH_WAIT_PROG  = 2'd2;
    localparam logic [1:0] PH_COMPARE    = 2'd3;

    // Configuration register indexes.
    localparam logic REG_BLOCK_SHIFT = 1'b0;
    localparam logic REG_PAGE_BYTES  = 1'b1;

    localparam int CFG_DATA_W = 13;

    // Effective sizes after reset: a 4 KiB erase block and a 128-byte page.
    localparam logic [16:0] BLOCK_SIZE_RESET = 17'd4096;
    localparam logic [12:0] PAGE_SIZE_RESET  = 13'd128;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] target_address;
        logic [23:0] job_length;
        logic [31:0] source_word;
        logic [31:0] flash_word;
    } item_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] command_address;
        logic [16:0] command_bytes;
        logic [23:0] source_offset;
    } result_t;

    typedef struct packed {
        logic job_idle;
        logic compare_active;
    } status_t;

    // Erase block size in bytes, with the shift clamped to 8..16.
    function automatic logic [16:0] block_size_of(input logic [4:0] shift);
        logic [4:0] s;
        s = shift;
        if (s < 5'd8) s = 5'd8;
        if (s > 5'd16) s = 5'd16;
        return 17'd1 << s;
    endfunction

    // Page size in bytes: word aligned, clamped to 4..4096.
    function automatic logic [12:0] page_size_of(input logic [12:0] bytes);
        logic [12:0] p;
        p = {bytes[12:2], 2'b00};
        if (p < 13'd4) p = 13'd4;
        if (p > 13'd4096) p = 13'd4096;
        return p;
    endfunction

    function automatic logic [16:0] block_min(input logic [31:0] avail,
                                              input logic [16:0] size);
        return (avail < {15'd0, size}) ? avail[16:0] : size;
    endfunction

    function automatic logic [12:0] page_min(input logic [31:0] avail,
                                             input logic [12:0] size);
        return (avail < {19'd0, size}) ? avail[12:0] : size;
    endfunction

endpackage

@@ rtl/fus_in_stage.sv @@
// Input register of the flash update sequencer: takes one transfer from the
// slave-side stream and holds it until the core consumes it.
// Depends on fus_pkg for the item struct.
module fus_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [119:0]     s_axis_tdata,
    input  logic [2:0]       s_axis_tuser,
    input  logic             advance,
    output fus_pkg::item_t   item,
    output logic             item_valid
);

    logic           valid_reg;
    fus_pkg::item_t item_reg;
    logic           take;

    // The slot frees up in the same cycle the core consumes its item.
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action         <= s_axis_tuser;
            item_reg.target_address <= s_axis_tdata[31:0];
            item_reg.job_length     <= s_axis_tdata[55:32];
            item_reg.source_word    <= s_axis_tdata[87:56];
            item_reg.flash_word     <= s_axis_tdata[119:88];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ rtl/fus_core.sv @@
// Job state and decision logic of the flash update sequencer, plus the
// configuration registers. One item is evaluated per cycle, when advance is set.
// Depends on fus_pkg for codes, structs and size helpers.
module fus_core
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [fus_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fus_pkg::item_t                    item,
    input  logic                              item_valid,
    input  logic                              advance,
    output fus_pkg::result_t                  result,
    output logic                              emit,
    output fus_pkg::status_t                  status
);

    localparam logic [LENGTH_BITS-1:0] LEN_ALIGN = {{(LENGTH_BITS-2){1'b1}}, 2'b00};

    logic [16:0]            block_size_reg;
    logic [12:0]            page_size_reg;

    logic [1:0]             job_mode_reg, job_mode_next;
    logic [1:0]             step_phase_reg, step_phase_next;
    logic [31:0]            current_address_reg, current_address_next;
    logic [LENGTH_BITS-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic [16:0]            block_chunk_reg, block_chunk_next;
    logic [16:0]            block_bytes_left_reg, block_bytes_left_next;
    logic [12:0]            page_chunk_reg, page_chunk_next;
    logic [LENGTH_BITS-1:0] source_position_reg, source_position_next;
    logic [14:0]            words_compared_reg, words_compared_next;
    logic                   mismatch_seen_reg, mismatch_seen_next;
    logic                   erase_needed_reg, erase_needed_next;

    // Shared candidate values for the next step.
    logic [LENGTH_BITS-1:0] start_len;
    logic [LENGTH_BITS-1:0] rem_after_block;
    logic [LENGTH_BITS-1:0] rem_after_page;
    logic [16:0]            left_after_page;
    logic [31:0]            addr_after_block;
    logic [31:0]            addr_after_page;
    logic [LENGTH_BITS-1:0] src_after_block;
    logic [LENGTH_BITS-1:0] src_after_page;
    logic [16:0]            next_block_chunk;
    logic [14:0]            words_inc;
    logic                   mismatch_now;
    logic                   erase_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= fus_pkg::BLOCK_SIZE_RESET;
            page_size_reg  <= fus_pkg::PAGE_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fus_pkg::REG_BLOCK_SHIFT: block_size_reg <= fus_pkg::block_size_of(cfg_data[4:0]);
                fus_pkg::REG_PAGE_BYTES:  page_size_reg  <= fus_pkg::page_size_of(cfg_data);
                default:                  page_size_reg  <= page_size_reg;
            endcase
        end
    end

    assign start_len        = LENGTH_BITS'(item.job_length) & LEN_ALIGN;
    assign rem_after_block  = bytes_remaining_reg - LENGTH_BITS'(block_chunk_reg);
    assign rem_after_page   = bytes_remaining_reg - LENGTH_BITS'(page_chunk_reg);
    assign left_after_page  = block_bytes_left_reg - {4'd0, page_chunk_reg};
    assign addr_after_block = current_address_reg + {15'd0, block_chunk_reg};
    assign addr_after_page  = current_address_reg + {19'd0, page_chunk_reg};
    assign src_after_block  = source_position_reg + LENGTH_BITS'(block_chunk_reg);
    assign src_after_page   = source_position_reg + LENGTH_BITS'(page_chunk_reg);
    assign next_block_chunk = fus_pkg::block_min(32'(rem_after_block), block_size_reg);
    assign words_inc        = words_compared_reg + 15'd1;
    assign mismatch_now     = mismatch_seen_reg || (item.source_word != item.flash_word);
    assign erase_now        = erase_needed_reg ||
                              ((item.source_word & item.flash_word) != item.source_word);

    always_comb
    begin
        job_mode_next         = job_mode_reg;
        step_phase_next       = step_phase_reg;
        current_address_next  = current_address_reg;
        bytes_remaining_next  = bytes_remaining_reg;
        block_chunk_next      = block_chunk_reg;
        block_bytes_left_next = block_bytes_left_reg;
        page_chunk_next       = page_chunk_reg;
        source_position_next  = source_position_reg;
        words_compared_next   = words_compared_reg;
        mismatch_seen_next    = mismatch_seen_reg;
        erase_needed_next     = erase_needed_reg;
        emit                   = 1'b0;
        result.command         = fus_pkg::CMD_NONE;
        result.command_address = current_address_reg;
        result.command_bytes   = 17'd0;
        result.source_offset   = 24'd0;

        unique case (item.action)
            fus_pkg::ACT_START_ERASE, fus_pkg::ACT_START_WRITE, fus_pkg::ACT_START_COPY:
            begin
                // A start while a job runs is dropped.
                if (job_mode_reg == fus_pkg::MODE_IDLE)
                begin
                    current_address_next   = item.target_address;
                    bytes_remaining_next   = start_len;
                    source_position_next   = '0;
                    emit                   = 1'b1;
                    result.command_address = item.target_address;
                    if (start_len == '0)
                    begin
                        result.command = fus_pkg::CMD_JOB_DONE;
                    end
                    else if (item.action == fus_pkg::ACT_START_ERASE)
                    begin
                        job_mode_next        = fus_pkg::MODE_ERASE;
                        step_phase_next      = fus_pkg::PH_WAIT_ERASE;
                        block_chunk_next     = fus_pkg::block_min(32'(start_len), block_size_reg);
                        result.command       = fus_pkg::CMD_ERASE;
                        result.command_bytes = block_chunk_next;
                    end
                    else if (item.action == fus_pkg::ACT_START_WRITE)
                    begin
                        job_mode_next        = fus_pkg::MODE_WRITE;
                        step_phase_next      = fus_pkg::PH_WAIT_PROG;
                        page_chunk_next      = fus_pkg::page_min(32'(start_len), page_size_reg);
                        result.command       = fus_pkg::CMD_PROGRAM;
                        result.command_bytes = {4'd0, page_chunk_next};
                    end
                    else
                    begin
                        job_mode_next         = fus_pkg::MODE_COPY;
                        step_phase_next       = fus_pkg::PH_COMPARE;
                        block_chunk_next      = fus_pkg::block_min(32'(start_len), block_size_reg);
                        block_bytes_left_next = block_chunk_next;
                        words_compared_next   = '0;
                        mismatch_seen_next    = 1'b0;
                        erase_needed_next     = 1'b0;
                        result.command        = fus_pkg::CMD_COMPARE;
                        result.command_bytes  = block_chunk_next;
                    end
                end
            end

            fus_pkg::ACT_FLASH_DONE:
            begin
                if (step_phase_reg == fus_pkg::PH_WAIT_ERASE)
                begin
                    if (job_mode_reg == fus_pkg::MODE_ERASE)
                    begin
                        current_address_next   = addr_after_block;
                        bytes_remaining_next   = rem_after_block;
                        emit                   = 1'b1;
                        result.command_address = addr_after_block;
                        if (rem_after_block != '0)
                        begin
                            block_chunk_next     = next_block_chunk;
                            result.command       = fus_pkg::CMD_ERASE;
                            result.command_bytes = next_block_chunk;
                        end
                        else
                        begin
                            job_mode_next   = fus_pkg::MODE_IDLE;
                            step_phase_next = fus_pkg::PH_NONE;
                            result.command  = fus_pkg::CMD_JOB_DONE;
                        end
                    end
                    else if (job_mode_reg == fus_pkg::MODE_COPY)
                    begin
                        // Block erased: start programming it.
                        step_phase_next      = fus_pkg::PH_WAIT_PROG;
                        page_chunk_next      = fus_pkg::page_min(32'(block_bytes_left_reg),
                                                                 page_size_reg);
                        emit                 = 1'b1;
                        result.command       = fus_pkg::CMD_PROGRAM;
                        result.command_bytes = {4'd0, page_chunk_next};
                        result.source_offset = 24'(source_position_reg);
                    end
                end
                else if (step_phase_reg == fus_pkg::PH_WAIT_PROG)
                begin
                    current_address_next   = addr_after_page;
                    source_position_next   = src_after_page;
                    result.command_address = addr_after_page;
                    if (job_mode_reg == fus_pkg::MODE_WRITE)
                    begin
                        bytes_remaining_next = rem_after_page;
                        emit                 = 1'b1;
                        if (rem_after_page != '0)
                        begin
                            page_chunk_next      = fus_pkg::page_min(32'(rem_after_page),
                                                                     page_size_reg);
                            result.command       = fus_pkg::CMD_PROGRAM;
                            result.command_bytes = {4'd0, page_chunk_next};
                            result.source_offset = 24'(src_after_page);
                        end
                        else
                        begin
                            job_mode_next   = fus_pkg::MODE_IDLE;
                            step_phase_next = fus_pkg::PH_NONE;
                            result.command  = fus_pkg::CMD_JOB_DONE;
                        end
                    end
                    else if (job_mode_reg == fus_pkg::MODE_COPY)
                    begin
                        block_bytes_left_next = left_after_page;
                        emit                  = 1'b1;
                        if (left_after_page != 17'd0)
                        begin
                            page_chunk_next      = fus_pkg::page_min(32'(left_after_page),
                                                                     page_size_reg);
                            result.command       = fus_pkg::CMD_PROGRAM;
                            result.command_bytes = {4'd0, page_chunk_next};
                            result.source_offset = 24'(src_after_page);
                        end
                        else
                        begin
                            // Block fully programmed: move on to the next block.
                            bytes_remaining_next = rem_after_block;
                            if (rem_after_block != '0)
                            begin
                                step_phase_next       = fus_pkg::PH_COMPARE;
                                block_chunk_next      = next_block_chunk;
                                block_bytes_left_next = next_block_chunk;
                                words_compared_next   = '0;
                                mismatch_seen_next    = 1'b0;
                                erase_needed_next     = 1'b0;
                                result.command        = fus_pkg::CMD_COMPARE;
                                result.command_bytes  = next_block_chunk;
                                result.source_offset  = 24'(src_after_page);
                            end
                            else
                            begin
                                job_mode_next   = fus_pkg::MODE_IDLE;
                                step_phase_next = fus_pkg::PH_NONE;
                                result.command  = fus_pkg::CMD_JOB_DONE;
                            end
                        end
                    end
                end
            end

            fus_pkg::ACT_COMPARE:
            begin
                if (step_phase_reg == fus_pkg::PH_COMPARE && job_mode_reg == fus_pkg::MODE_COPY)
                begin
                    mismatch_seen_next  = mismatch_now;
                    erase_needed_next   = erase_now;
                    words_compared_next = words_inc;
                    if (words_inc >= block_chunk_reg[16:2])
                    begin
                        emit = 1'b1;
                        if (!mismatch_now)
                        begin
                            // Identical block: skip it.
                            current_address_next   = addr_after_block;
                            source_position_next   = src_after_block;
                            bytes_remaining_next   = rem_after_block;
                            result.command_address = addr_after_block;
                            if (rem_after_block != '0)
                            begin
                                block_chunk_next      = next_block_chunk;
                                block_bytes_left_next = next_block_chunk;
                                words_compared_next   = '0;
                                mismatch_seen_next    = 1'b0;
                                erase_needed_next     = 1'b0;
                                result.command        = fus_pkg::CMD_COMPARE;
                                result.command_bytes  = next_block_chunk;
                                result.source_offset  = 24'(src_after_block);
                            end
                            else
                            begin
                                job_mode_next   = fus_pkg::MODE_IDLE;
                                step_phase_next = fus_pkg::PH_NONE;
                                result.command  = fus_pkg::CMD_JOB_DONE;
                            end
                        end
                        else if (erase_now)
                        begin
                            step_phase_next      = fus_pkg::PH_WAIT_ERASE;
                            result.command       = fus_pkg::CMD_ERASE;
                            result.command_bytes = block_chunk_reg;
                        end
                        else
                        begin
                            step_phase_next      = fus_pkg::PH_WAIT_PROG;
                            page_chunk_next      = fus_pkg::page_min(32'(block_bytes_left_reg),
                                                                     page_size_reg);
                            result.command       = fus_pkg::CMD_PROGRAM;
                            result.command_bytes = {4'd0, page_chunk_next};
                            result.source_offset = 24'(source_position_reg);
                        end
                    end
                end
            end

            default:
            begin
                emit = 1'b0;
            end
        endcase

        emit = emit && item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_mode_reg         <= fus_pkg::MODE_IDLE;
            step_phase_reg       <= fus_pkg::PH_NONE;
            current_address_reg  <= '0;
            bytes_remaining_reg  <= '0;
            block_chunk_reg      <= '0;
            block_bytes_left_reg <= '0;
            page_chunk_reg       <= '0;
            source_position_reg  <= '0;
            words_compared_reg   <= '0;
            mismatch_seen_reg    <= 1'b0;
            erase_needed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            job_mode_reg         <= job_mode_next;
            step_phase_reg       <= step_phase_next;
            current_address_reg  <= current_address_next;
            bytes_remaining_reg  <= bytes_remaining_next;
            block_chunk_reg      <= block_chunk_next;
            block_bytes_left_reg <= block_bytes_left_next;
            page_chunk_reg       <= page_chunk_next;
            source_position_reg  <= source_position_next;
            words_compared_reg   <= words_compared_next;
            mismatch_seen_reg    <= mismatch_seen_next;
            erase_needed_reg     <= erase_needed_next;
        end
    end

    assign status.job_idle       = (job_mode_reg == fus_pkg::MODE_IDLE);
    assign status.compare_active = (step_phase_reg == fus_pkg::PH_COMPARE);

endmodule

@@ rtl/fus_out_stage.sv @@
// Result register of the flash update sequencer: holds one command until the
// master-side stream takes it.
// Depends on fus_pkg for the result struct.
module fus_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  fus_pkg::result_t   result,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [79:0]        m_axis_tdata,
    output logic [2:0]         m_axis_tuser
);

    logic             valid_reg;
    fus_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = result_reg.command;
    assign m_axis_tdata  = {7'd0, result_reg.source_offset, result_reg.command_bytes,
                            result_reg.command_address};

endmodule

@@ rtl/flash_update_sequencer_top.sv @@
// A command passes two registers after its input transfer: the input register, then the result register.
// Throughput: one input transfer per cycle while the master side keeps taking results.
// The whole decision for an item is one pass through the job registers in fus_core.
// Reset (rst_n low, asynchronous): both stream registers empty, the job idle with all
// counters cleared, erase block size 4096 bytes and page size 128 bytes.
module flash_update_sequencer_top
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,

    // Configuration writes: index 0 is block_shift, index 1 is page_bytes.
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0 up: target_address[31:0], job_length[23:0], source_word[31:0],
    // flash_word[31:0].
    input  logic [119:0] s_axis_tdata,
    // action[2:0]: start erase, start write, start copy, flash done or compare word.
    input  logic [2:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0 up: command_address[31:0], command_bytes[16:0], source_offset[23:0],
    // then seven zero bits.
    output logic [79:0]  m_axis_tdata,
    // command[2:0]: erase block, program page, compare request or job completed.
    output logic [2:0]   m_axis_tuser
);

    fus_pkg::item_t   item;
    logic             item_valid;
    fus_pkg::result_t result;
    logic             emit;
    fus_pkg::status_t status;
    logic             advance;

    // The held item is evaluated whenever the result register is free or being
    // emptied in this cycle. Items that cause no command still advance the job
    // state, so they never wait on the master side beyond that condition.
    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    fus_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item          (item),
        .item_valid    (item_valid)
    );

    // Job sequencing: starts, flash done events and compare words each update
    // the job registers and produce at most one command.
    fus_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .emit       (emit),
        .status     (status)
    );

    fus_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && emit),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A completion command always leaves the job idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && result.command == fus_pkg::CMD_JOB_DONE) |=> status.job_idle)
        else $error("job still active after a completion command");

    // While a held item is blocked by a stalled result, no new transfer is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is stalled");

    // Erase, program and compare commands never cover zero bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != fus_pkg::CMD_JOB_DONE)
        |-> (m_axis_tdata[48:32] != 17'd0))
        else $error("flash command with zero byte count");

    // Compare words are collected only while a copy job is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.compare_active |-> !status.job_idle)
        else $error("compare phase without an active job");

endmodule

@@ bench/fus_command_checker.sv @@
// Command checker for the flash update sequencer: predicts the command stream from
// the observed input and configuration transfers and compares every result transfer.
// Depends on fus_pkg for the action, command, mode and phase codes and the item types.
`timescale 1ns / 1ps

module fus_command_checker
    import fus_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [79:0]  m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    output int           fail_count,
    output int           awaited,
    output int           checked
);

    // Own copy of the configuration and the job registers.
    logic [4:0]  shift_reg;
    logic [12:0] page_reg;
    logic [1:0]  mode;
    logic [1:0]  phase;
    logic [31:0] addr;
    logic [23:0] remaining;
    logic [23:0] src_pos;
    logic [16:0] blk_chunk;
    logic [16:0] blk_left;
    logic [12:0] pg_chunk;
    logic [14:0] n_compared;
    logic        any_diff;
    logic        must_erase;

    result_t expected_cmds[$];

    function automatic logic [16:0] block_bytes_for(input logic [4:0] sh);
        logic [4:0] s;
        s = sh;
        if (s < 5'd8) s = 5'd8;
        if (s > 5'd16) s = 5'd16;
        return 17'd1 << s;
    endfunction

    function automatic logic [12:0] page_bytes_for(input logic [12:0] pb);
        logic [12:0] p;
        p = pb & 13'h1FFC;
        if (p < 13'd4) p = 13'd4;
        if (p > 13'd4096) p = 13'd4096;
        return p;
    endfunction

    function automatic void issue(input logic [2:0] cmd, input logic [31:0] a,
                                  input logic [16:0] n, input logic [23:0] off);
        result_t r;
        r.command         = cmd;
        r.command_address = a;
        r.command_bytes   = n;
        r.source_offset   = off;
        expected_cmds.push_back(r);
    endfunction

    function automatic logic [16:0] next_block_len();
        logic [16:0] b;
        b = block_bytes_for(shift_reg);
        return ({8'd0, remaining} < {15'd0, b}) ? remaining[16:0] : b;
    endfunction

    function automatic void close_job();
        mode  = MODE_IDLE;
        phase = PH_NONE;
        issue(CMD_JOB_DONE, addr, 17'd0, 24'd0);
    endfunction

    function automatic void erase_next();
        blk_chunk = next_block_len();
        phase     = PH_WAIT_ERASE;
        issue(CMD_ERASE, addr, blk_chunk, 24'd0);
    endfunction

    function automatic void compare_next();
        blk_chunk  = next_block_len();
        blk_left   = blk_chunk;
        n_compared = '0;
        any_diff   = 1'b0;
        must_erase = 1'b0;
        phase      = PH_COMPARE;
        issue(CMD_COMPARE, addr, blk_chunk, src_pos);
    endfunction

    function automatic void program_next(input logic [31:0] avail);
        logic [12:0] p;
        p        = page_bytes_for(page_reg);
        pg_chunk = (avail < {19'd0, p}) ? avail[12:0] : p;
        phase    = PH_WAIT_PROG;
        issue(CMD_PROGRAM, addr, {4'd0, pg_chunk}, src_pos);
    endfunction

    function automatic void block_finished();
        remaining = remaining - blk_chunk;
        if (remaining != 0) compare_next();
        else close_job();
    endfunction

    // One accepted input item moves the job registers and may add one command.
    function automatic void advance_sequencer(input item_t it);
        case (it.action)
            ACT_START_ERASE, ACT_START_WRITE, ACT_START_COPY:
            begin
                if (mode == MODE_IDLE)
                begin
                    addr      = it.target_address;
                    remaining = {it.job_length[23:2], 2'b00};
                    src_pos   = '0;
                    if (remaining == 0) close_job();
                    else if (it.action == ACT_START_ERASE)
                    begin
                        mode = MODE_ERASE;
                        erase_next();
                    end
                    else if (it.action == ACT_START_WRITE)
                    begin
                        mode = MODE_WRITE;
                        program_next({8'd0, remaining});
                    end
                    else
                    begin
                        mode = MODE_COPY;
                        compare_next();
                    end
                end
            end
            ACT_FLASH_DONE:
            begin
                if (phase == PH_WAIT_ERASE)
                begin
                    if (mode == MODE_ERASE)
                    begin
                        addr      = addr + blk_chunk;
                        remaining = remaining - blk_chunk;
                        if (remaining != 0) erase_next();
                        else close_job();
                    end
                    else if (mode == MODE_COPY) program_next({15'd0, blk_left});
                end
                else if (phase == PH_WAIT_PROG)
                begin
                    addr    = addr + pg_chunk;
                    src_pos = src_pos + pg_chunk;
                    if (mode == MODE_WRITE)
                    begin
                        remaining = remaining - pg_chunk;
                        if (remaining != 0) program_next({8'd0, remaining});
                        else close_job();
                    end
                    else if (mode == MODE_COPY)
                    begin
                        blk_left = blk_left - pg_chunk;
                        if (blk_left != 0) program_next({15'd0, blk_left});
                        else block_finished();
                    end
                end
            end
            ACT_COMPARE:
            begin
                if (phase == PH_COMPARE && mode == MODE_COPY)
                begin
                    if (it.source_word != it.flash_word) any_diff = 1'b1;
                    if ((it.source_word & it.flash_word) != it.source_word) must_erase = 1'b1;
                    n_compared = n_compared + 1'b1;
                    if ({2'b00, n_compared} >= (blk_chunk >> 2))
                    begin
                        if (!any_diff)
                        begin
                            addr    = addr + blk_chunk;
                            src_pos = src_pos + blk_chunk;
                            block_finished();
                        end
                        else if (must_erase)
                        begin
                            phase = PH_WAIT_ERASE;
                            issue(CMD_ERASE, addr, blk_chunk, 24'd0);
                        end
                        else program_next({15'd0, blk_left});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        item_t   it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            shift_reg  = 5'd12;
            page_reg   = 13'd128;
            mode       = MODE_IDLE;
            phase      = PH_NONE;
            addr       = '0;
            remaining  = '0;
            src_pos    = '0;
            blk_chunk  = '0;
            blk_left   = '0;
            pg_chunk   = '0;
            n_compared = '0;
            any_diff   = 1'b0;
            must_erase = 1'b0;
            expected_cmds.delete();
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_BLOCK_SHIFT) shift_reg = cfg_data[4:0];
                else page_reg = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.action         = s_axis_tuser;
                it.target_address = s_axis_tdata[31:0];
                it.job_length     = s_axis_tdata[55:32];
                it.source_word    = s_axis_tdata[87:56];
                it.flash_word     = s_axis_tdata[119:88];
                advance_sequencer(it);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.command         = m_axis_tuser;
                got.command_address = m_axis_tdata[31:0];
                got.command_bytes   = m_axis_tdata[48:32];
                got.source_offset   = m_axis_tdata[72:49];
                checked = checked + 1;
                if (expected_cmds.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing expected: %s %0d %h %0d %0d",
                                 checked, "cmd/addr/bytes/offset", got.command,
                                 got.command_address, got.command_bytes,
                                 got.source_offset);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.command != want.command ||
                        got.command_address != want.command_address ||
                        got.command_bytes != want.command_bytes ||
                        got.source_offset != want.source_offset)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                        begin
                            $display("result %0d mismatch: expected cmd %0d addr %h bytes %0d offset %0d",
                                     checked, want.command, want.command_address,
                                     want.command_bytes, want.source_offset);
                            $display("    got cmd %0d addr %h bytes %0d offset %0d",
                                     got.command, got.command_address,
                                     got.command_bytes, got.source_offset);
                        end
                    end
                end
            end
        end
        awaited = expected_cmds.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the flash update sequencer testbench: clock, reset, job stimulus that answers
// the block's commands like a flash controller, random stalls and the final verdict.
// Depends on fus_pkg, flash_update_sequencer_top and fus_command_checker.
`timescale 1ns / 1ps

module tb_top;
    import fus_pkg::*;

    localparam int ITEM_GOAL     = 1650;
    // Cycles without any transfer before the run is declared hung. The longest honest
    // quiet stretch is a long sender gap plus a long receiver stall plus a settle pause.
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 10;

    // Actions that the block does not define; it must drop them.
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    // How one source/flash word pair relates.
    localparam int PAIR_EQUAL = 0;   // identical words
    localparam int PAIR_GROW  = 1;   // flash has extra ones: programmable without erase
    localparam int PAIR_LOSE  = 2;   // flash lost a one of the source: needs an erase

    // What a whole compared block should lead to.
    localparam int BLK_SKIP    = 0;
    localparam int BLK_PROGRAM = 1;
    localparam int BLK_ERASE   = 2;
    localparam int BLK_ANY     = 3;

    // Where an ignored item is injected.
    localparam int NOISE_IDLE      = 0;
    localparam int NOISE_WAITING   = 1;
    localparam int NOISE_COMPARING = 2;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [12:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;     // target_address, job_length, source_word, flash_word
    logic [2:0]   s_axis_tuser;     // action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;     // command_address, command_bytes, source_offset, zeros
    logic [2:0]   m_axis_tuser;     // command

    int fail_count;
    int awaited;
    int checked;

    // Commands seen on the master side, consumed by the stimulus to answer them.
    result_t observed[$];

    int items_sent = 0;
    int noise_sent = 0;
    int settings_used = 0;
    int jobs_run[3];
    int idle_cycles = 0;
    int hold_left = 0;
    int blk_eff = 4096;
    int pg_eff = 128;
    bit burst = 1'b0;

    flash_update_sequencer_top #(.LENGTH_BITS(24)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fus_command_checker check_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .awaited       (awaited),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: mostly ready, with short and occasional long stalls. During a burst
    // stretch it takes every result at once.
    always @(posedge clk)
    begin
        int roll;
        roll = $urandom_range(0, 99);
        if (hold_left > 0)
            hold_left = hold_left - 1;
        else if (burst || roll < 60)
        begin
            m_axis_tready <= 1'b1;
            hold_left = $urandom_range(0, 6);
        end
        else if (roll < 92)
        begin
            m_axis_tready <= 1'b0;
            hold_left = $urandom_range(0, 2);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            hold_left = $urandom_range(10, 50);
        end
    end

    // Record every command transfer so the stimulus can play the flash controller.
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            r.command         = m_axis_tuser;
            r.command_address = m_axis_tdata[31:0];
            r.command_bytes   = m_axis_tdata[48:32];
            r.source_offset   = m_axis_tdata[72:49];
            observed.push_back(r);
        end
    end

    // Watchdog: a hung block shows up as a long run of cycles with no transfer at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_item(input logic [2:0] act, input logic [31:0] a,
                                        input logic [23:0] n, input logic [31:0] s,
                                        input logic [31:0] f);
        item_t it;
        it.action         = act;
        it.target_address = a;
        it.job_length     = n;
        it.source_word    = s;
        it.flash_word     = f;
        return it;
    endfunction

    // Offer one item and return at the edge where it was taken. Valid stays high so a
    // following item can go back to back; callers that wait lower it first. Ready is
    // looked at on the falling edge, where it is stable.
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.flash_word, it.source_word, it.job_length, it.target_address};
        s_axis_tuser  <= it.action;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
    endtask

    // Wait for the next command from the block; the queue is read on falling edges so
    // the result never depends on the order of processes at a rising edge.
    task automatic await_command(output result_t r);
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (observed.size() == 0);
        r = observed.pop_front();
        @(posedge clk);
    endtask

    // Hold off the sender until every predicted command has arrived, then give the
    // two-stage pipeline time to swallow any trailing ignored item.
    task automatic settle();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [4:0] shift, input logic [12:0] page);
        logic [7:0] spare;
        int s;
        spare = $urandom;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLOCK_SHIFT;
        cfg_data  <= {spare, shift};      // upper bits are not part of the register
        @(posedge clk);
        cfg_index <= REG_PAGE_BYTES;
        cfg_data  <= page;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        // Effective sizes, only used to keep job lengths affordable.
        s = (shift < 8) ? 8 : (shift > 16) ? 16 : shift;
        blk_eff = 1 << s;
        pg_eff = page & 13'h1FFC;
        if (pg_eff < 4) pg_eff = 4;
        if (pg_eff > 4096) pg_eff = 4096;
        settings_used++;
    endtask

    // An item the block must ignore in the given situation.
    task automatic send_noise(input int where);
        logic [2:0] act;
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            act = $urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST);
        else if (where == NOISE_IDLE)
            act = (pick == 1) ? ACT_FLASH_DONE : ACT_COMPARE;
        else if (where == NOISE_WAITING)
            act = (pick == 1) ? ACT_COMPARE : $urandom_range(ACT_START_ERASE, ACT_START_COPY);
        else
            act = (pick == 1) ? ACT_FLASH_DONE : $urandom_range(ACT_START_ERASE, ACT_START_COPY);
        send_item(make_item(act, $urandom, $urandom, $urandom, $urandom));
        noise_sent++;
    endtask

    task automatic make_pair(input int kind, output logic [31:0] s, output logic [31:0] f);
        int k;
        s = $urandom;
        k = $urandom_range(0, 31);
        if (kind == PAIR_EQUAL)
            f = s;
        else if (kind == PAIR_GROW)
        begin
            s[k] = 1'b0;
            f = s | $urandom;
            f[k] = 1'b1;
        end
        else
        begin
            s[k] = 1'b1;
            f = s ^ $urandom;
            f[k] = 1'b0;
        end
    endtask

    // Start one job and answer its commands until it completes: a done transfer for
    // every erase or program, and one pair per word for every compare request.
    task automatic run_job(input logic [2:0] act, input logic [31:0] base,
                           input logic [23:0] len, input int noise_pct, input int block_plan);
        result_t cmd;
        int words;
        int forced;
        int plan;
        int kind;
        logic [31:0] s;
        logic [31:0] f;
        bit running;
        send_item(make_item(act, base, len, $urandom, $urandom));
        items_sent++;
        jobs_run[act]++;
        running = 1'b1;
        while (running)
        begin
            await_command(cmd);
            if (cmd.command == CMD_JOB_DONE)
                running = 1'b0;
            else if (cmd.command == CMD_COMPARE)
            begin
                words = cmd.command_bytes >> 2;
                plan = (block_plan == BLK_ANY) ? $urandom_range(BLK_SKIP, BLK_ERASE) : block_plan;
                forced = (words > 0) ? $urandom_range(0, words - 1) : 0;
                for (int i = 0; i < words; i++)
                begin
                    if ($urandom_range(0, 99) < noise_pct) send_noise(NOISE_COMPARING);
                    if (plan == BLK_SKIP)
                        kind = PAIR_EQUAL;
                    else if (i == forced)
                        kind = (plan == BLK_PROGRAM) ? PAIR_GROW : PAIR_LOSE;
                    else if (plan == BLK_PROGRAM)
                        kind = $urandom_range(PAIR_EQUAL, PAIR_GROW);
                    else
                        kind = $urandom_range(PAIR_EQUAL, PAIR_LOSE);
                    make_pair(kind, s, f);
                    send_item(make_item(ACT_COMPARE, $urandom, $urandom, s, f));
                    items_sent++;
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < noise_pct) send_noise(NOISE_WAITING);
                send_item(make_item(ACT_FLASH_DONE, $urandom, $urandom, $urandom, $urandom));
                items_sent++;
            end
        end
    endtask

    initial
    begin
        logic [2:0]  act;
        logic [4:0]  shift;
        logic [12:0] page;
        logic [23:0] len;
        int cap;
        int jobs_left;
        int r;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_BLOCK_SHIFT;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_START_ERASE;
        jobs_run[0] = 0;
        jobs_run[1] = 0;
        jobs_run[2] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the reset sizes (4 KiB blocks, 128-byte pages).
        // Stray done, stray compare word and undefined actions while idle.
        send_item(make_item(ACT_FLASH_DONE, $urandom, $urandom, $urandom, $urandom));
        send_item(make_item(ACT_COMPARE, $urandom, $urandom, $urandom, $urandom));
        send_item(make_item(ACT_UNUSED_LAST, $urandom, $urandom, $urandom, $urandom));
        noise_sent += 3;
        // Zero-length jobs complete at once; a length below four also counts as zero.
        run_job(ACT_START_ERASE, 32'h0000_1000, 24'd0, 0, BLK_ANY);
        run_job(ACT_START_WRITE, 32'hFFFF_FFFF, 24'd3, 0, BLK_ANY);
        run_job(ACT_START_COPY, 32'h8000_0000, 24'd2, 0, BLK_ANY);
        // Write with a short last page, crossing the top of the address space, with
        // ignored items thrown in at every step.
        run_job(ACT_START_WRITE, 32'hFFFF_FF80, 24'd302, 100, BLK_ANY);

        // Smallest sizes: the shift clamps up to 256-byte blocks, the page up to 4 bytes.
        settle();
        configure(5'd0, 13'd2);
        run_job(ACT_START_COPY, 32'h0002_0000, 24'd16, 0, BLK_SKIP);
        run_job(ACT_START_COPY, 32'h0002_0010, 24'd16, 0, BLK_PROGRAM);
        run_job(ACT_START_COPY, 32'h0002_0020, 24'd16, 100, BLK_ERASE);
        run_job(ACT_START_ERASE, 32'h0000_0100, 24'd1020, 50, BLK_ANY);

        // Largest sizes: 64 KiB blocks and 4 KiB pages, the longest possible length.
        settle();
        configure(5'd31, 13'd8191);
        run_job(ACT_START_ERASE, 32'hFFFF_0000, 24'hFF_FFFF, 0, BLK_ANY);
        run_job(ACT_START_WRITE, 32'h0000_0000, 24'd8196, 0, BLK_ANY);
        run_job(ACT_START_COPY, 32'hFFFF_FFF0, 24'd64, 0, BLK_ERASE);

        // A large erase block with tiny pages: one erased block becomes many programs.
        settle();
        configure(5'd16, 13'd4);
        run_job(ACT_START_COPY, 32'h1234_5678, 24'd64, 30, BLK_ERASE);

        // Random part: phases of jobs under one setting each, mostly small sizes.
        jobs_left = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (jobs_left == 0)
            begin
                settle();
                r = $urandom_range(0, 9);
                if (r < 6) shift = $urandom_range(8, 10);
                else if (r < 8) shift = $urandom_range(0, 31);
                else shift = ($urandom_range(0, 1) == 0) ? 5'd8 : 5'd16;
                r = $urandom_range(0, 9);
                if (r < 4) page = $urandom_range(4, 64);
                else if (r < 7) page = $urandom_range(0, 8191);
                else
                begin
                    case ($urandom_range(0, 3))
                        0: page = 13'd4;
                        1: page = 13'd4096;
                        2: page = 13'd0;
                        default: page = 13'd8191;
                    endcase
                end
                configure(shift, page);
                jobs_left = $urandom_range(6, 14);
            end

            // Now and then a stretch with no idling on either side.
            burst = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0) send_noise(NOISE_IDLE);

            act = $urandom_range(ACT_START_ERASE, ACT_START_COPY);
            if (act == ACT_START_ERASE) cap = blk_eff * 6;
            else if (act == ACT_START_WRITE) cap = pg_eff * 24;
            else cap = (blk_eff * 2 < 768) ? blk_eff * 2 : 768;
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 3);
            else len = $urandom_range(0, cap);
            run_job(act, $urandom, len, 8, BLK_ANY);
            jobs_left--;

            // Occasionally let the block drain completely before the next job.
            if ($urandom_range(0, 9) == 0) settle();
        end

        burst = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Ran %0d erase, %0d write and %0d copy jobs under %0d size settings.",
                 jobs_run[0], jobs_run[1], jobs_run[2], settings_used + 1);
        $display("%0d job transfers and %0d ignored transfers in, %0d commands checked.",
                 items_sent, noise_sent, checked);
        if (fail_count == 0 && awaited == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
